>>> hdl/bfa_pkg.sv
// Shared types and constants for the best-fit buffer reuse allocator.
package bfa_pkg;

	localparam int DEF_MAX_BUFFERS = 64;
	localparam int DEF_POOL_COUNT  = 16;
	localparam int DEF_STEP_BITS   = 16;

	localparam int          SUM_W      = 48;
	localparam logic [47:0] SUM_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam int          ALIGN_W    = 13;
	localparam logic [12:0] ALIGN_RST  = 13'd64;
	localparam int          SIZE_W     = 33;

	typedef struct packed {
		logic [3:0]  pool_id;
		logic [15:0] first_step;
		logic [15:0] last_step;
		logic [31:0] byte_count;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  buffer_number;
		logic        reused;
		logic [3:0]  arena_number;
		logic [47:0] arena_offset;
		logic        table_full;
		logic [47:0] planned_total;
		logic [47:0] naive_total;
	} out_item_t;

	// Request to the remainder unit.
	typedef struct packed {
		logic        start;
		logic [47:0] dividend;
		logic [12:0] divisor;
	} rem_req_t;

	// Saturating add of two 48-bit values.
	function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? SUM_MAX : s[47:0];
	endfunction

endpackage

>>> hdl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/bfa_rem.sv
// Bit-serial remainder unit: 48-bit dividend modulo a 13-bit divisor, one bit per cycle.
module bfa_rem
	import bfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rem_req_t    req,
	output logic        busy,
	output logic        done,
	output logic [12:0] rem
);

	logic [47:0] dvd_q;
	logic [12:0] dvs_q;
	logic [12:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [13:0] trial;

	// One restoring step: shift in the next bit and subtract if it fits.
	always_comb begin
		trial = {rem_q, dvd_q[47]};
		if (trial >= {1'b0, dvs_q}) begin
			trial = trial - {1'b0, dvs_q};
		end
	end

	// Sequencer for the 48 steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[46:0], 1'b0};
			rem_q <= trial[12:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

	// A result never appears while a division is still running.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("remainder done while busy");

endmodule

>>> hdl/best_fit_buffer_reuse_allocator_top.sv
// Top level of the best-fit buffer reuse allocator.
//
//  channel | direction | handshake              | beat
//  in      | input     | in_valid / in_ready    | in_item_t: pool, steps, byte count
//  out     | output    | out_valid / out_ready  | out_item_t: buffer, arena, offset, totals
//  cfg     | input     | cfg_we                 | alignment, 13 bits
//
// A reuse runs from one accepted beat to the next through the bit-serial remainder unit,
// which aligns the size, a scan that reads the slot RAM entry of each stored buffer, and
// the handoffs between states. A new buffer also passes through ST_NEW; in a pool already
// in use it first takes another remainder pass, since the arena end is aligned. Reset
// clears all control state at once; slot entries are only read below the fill count, so
// no clearing pass is needed. A result waiting on out_ready blocks only when the next item
// reaches its output cycle.
module best_fit_buffer_reuse_allocator_top
	import bfa_pkg::*;
#(
	parameter int MAX_BUFFERS = DEF_MAX_BUFFERS,
	parameter int POOL_COUNT  = DEF_POOL_COUNT,
	parameter int STEP_BITS   = DEF_STEP_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [12:0] cfg_wdata
);

	localparam int BW  = $clog2(MAX_BUFFERS);
	localparam int CW  = $clog2(MAX_BUFFERS + 1);
	localparam int PW  = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
	localparam int SW  = (STEP_BITS < 16) ? STEP_BITS : 16;
	localparam int AW  = PW;
	localparam int AUW = $clog2(POOL_COUNT + 1);
	localparam int SLOT_W = SIZE_W + SW + PW + SUM_W;
	localparam int PRAM_W = AW + SUM_W;
	localparam int PDEPTH = (POOL_COUNT > 1) ? POOL_COUNT : 2;
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BUFFERS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SIZE, ST_SCAN, ST_DECIDE, ST_END, ST_NEW, ST_OUT
	} state_t;

	state_t state_q;

	logic [12:0]       align_q;
	logic [12:0]       align_eff;
	logic [PW-1:0]     pool_q;
	logic [SW-1:0]     first_q;
	logic [SW-1:0]     last_q;
	logic [SIZE_W-1:0] size_q;
	logic [31:0]       bytes_q;
	logic [CW-1:0]     slots_q;
	logic [AUW-1:0]    arenas_q;
	logic [47:0]       planned_q;
	logic [47:0]       naive_q;
	logic [POOL_COUNT-1:0] pvalid_q;

	logic [CW-1:0]     rd_idx_q;
	logic              vld_s1;
	logic [BW-1:0]     idx_s1;
	logic              found_q;
	logic [BW-1:0]     best_q;
	logic [SIZE_W-1:0] best_size_q;
	logic [47:0]       best_off_q;
	logic [47:0]       off_q;
	logic [AW-1:0]     arena_q;
	logic              new_pool_q;
	logic              full_q;
	logic              reused_q;
	logic [BW-1:0]     buf_q;

	rem_req_t    rreq;
	logic        r_busy;
	logic        r_done;
	logic [12:0] r_rem;

	logic              s_we;
	logic [BW-1:0]     s_waddr;
	logic [SLOT_W-1:0] s_wdata;
	logic              s_re;
	logic [SLOT_W-1:0] s_rdata;
	logic              p_we;
	logic              p_re;
	logic [PRAM_W-1:0] p_wdata;
	logic [PRAM_W-1:0] p_rdata;

	logic [PW-1:0]     in_pool;
	logic [SIZE_W-1:0] s_size;
	logic [SW-1:0]     s_last;
	logic [PW-1:0]     s_pool;
	logic [47:0]       s_off;
	logic [AW-1:0]     p_arena;
	logic [47:0]       p_end;
	logic              hit;
	logic [13:0]       pad;
	logic [31:0]       arena_wide;
	logic [31:0]       buf_wide;
	logic [48:0]       end_up;

	// Pool number modulo the pool count, one restoring step per input bit.
	always_comb begin
		logic [4:0] r;
		r = '0;
		for (int i = 3; i >= 0; i--) begin
			r = {r[3:0], in_data.pool_id[i]};
			if (32'(r) >= POOL_COUNT) begin
				r = 5'(32'(r) - POOL_COUNT);
			end
		end
		in_pool = PW'(r);
	end

	assign align_eff = (align_q == '0) ? 13'd1 : align_q;
	assign pad       = {1'b0, align_eff} - {1'b0, r_rem};
	assign in_ready  = (state_q == ST_IDLE);

	// Slot word fields.
	assign {s_size, s_last, s_pool, s_off} = s_rdata;
	assign {p_arena, p_end} = p_rdata;

	// Candidate test for the entry read in the previous cycle.
	assign hit = vld_s1 && (s_pool == pool_q) && (s_last < first_q) && (s_size >= size_q)
		&& (!found_q || (s_size < best_size_q));

	assign end_up = (r_rem == '0) ? {1'b0, p_end} : ({1'b0, p_end} + 49'(pad));

	// Remainder unit requests: byte count at acceptance, arena end before a new buffer.
	always_comb begin
		rreq.start    = 1'b0;
		rreq.dividend = {16'd0, in_data.byte_count};
		rreq.divisor  = align_eff;
		if (state_q == ST_IDLE && in_valid) begin
			rreq.start = 1'b1;
		end else if (state_q == ST_DECIDE) begin
			rreq.dividend = p_end;
			rreq.start    = !found_q && (slots_q != FULL_CNT) && pvalid_q[pool_q];
		end
	end

	// Slot RAM and pool RAM ports.
	always_comb begin
		s_re    = (state_q == ST_SCAN) && (rd_idx_q < slots_q);
		s_we    = 1'b0;
		s_waddr = best_q;
		s_wdata = {best_size_q, last_q, pool_q, best_off_q};
		if (state_q == ST_DECIDE && found_q) begin
			s_we = 1'b1;
		end else if (state_q == ST_NEW) begin
			s_we    = 1'b1;
			s_waddr = slots_q[BW-1:0];
			s_wdata = {size_q, last_q, pool_q, off_q};
		end
		p_re    = (state_q == ST_IDLE) && in_valid;
		p_we    = (state_q == ST_NEW);
		p_wdata = {arena_q, sat_add(off_q, {15'd0, size_q})};
	end

	bfa_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.busy   (r_busy),
		.done   (r_done),
		.rem    (r_rem)
	);

	bfa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BUFFERS)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (rd_idx_q[BW-1:0]),
		.rdata (s_rdata)
	);

	// The pool index already has the address width of the pool RAM.
	bfa_ram #(.WIDTH(PRAM_W), .DEPTH(PDEPTH)) u_pool_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (pool_q),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (in_pool),
		.rdata (p_rdata)
	);

	assign arena_wide = 32'(arena_q);
	assign buf_wide   = 32'(buf_q);

	// Sequencer with its state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			align_q   <= ALIGN_RST;
			slots_q   <= '0;
			arenas_q  <= '0;
			planned_q <= '0;
			naive_q   <= '0;
			pvalid_q  <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				align_q <= cfg_wdata;
			end
			if (out_valid && out_ready && state_q != ST_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pool_q  <= in_pool;
						first_q <= in_data.first_step[SW-1:0];
						last_q  <= (in_data.last_step[SW-1:0] < in_data.first_step[SW-1:0])
							? in_data.first_step[SW-1:0] : in_data.last_step[SW-1:0];
						bytes_q <= in_data.byte_count;
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					if (r_done) begin
						logic [SIZE_W-1:0] sz;
						sz = (r_rem == '0) ? {1'b0, bytes_q}
							: ({1'b0, bytes_q} + SIZE_W'(pad));
						size_q   <= sz;
						naive_q  <= sat_add(naive_q, {15'd0, sz});
						rd_idx_q <= '0;
						vld_s1   <= 1'b0;
						found_q  <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= s_re;
					idx_s1 <= rd_idx_q[BW-1:0];
					if (s_re) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (hit) begin
						found_q     <= 1'b1;
						best_q      <= idx_s1;
						best_size_q <= s_size;
						best_off_q  <= s_off;
					end
					if (!s_re && !vld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					reused_q   <= found_q;
					new_pool_q <= !pvalid_q[pool_q];
					if (found_q) begin
						full_q  <= 1'b0;
						buf_q   <= best_q;
						off_q   <= best_off_q;
						arena_q <= p_arena;
						state_q <= ST_OUT;
					end else if (slots_q == FULL_CNT) begin
						full_q  <= 1'b1;
						buf_q   <= '0;
						off_q   <= '0;
						arena_q <= '0;
						state_q <= ST_OUT;
					end else if (!pvalid_q[pool_q]) begin
						full_q  <= 1'b0;
						off_q   <= '0;
						arena_q <= AW'(arenas_q);
						state_q <= ST_NEW;
					end else begin
						full_q  <= 1'b0;
						arena_q <= p_arena;
						state_q <= ST_END;
					end
				end
				ST_END: begin
					if (r_done) begin
						off_q   <= end_up[48] ? SUM_MAX : end_up[47:0];
						state_q <= ST_NEW;
					end
				end
				ST_NEW: begin
					buf_q     <= slots_q[BW-1:0];
					slots_q   <= slots_q + CW'(1);
					planned_q <= sat_add(planned_q, {15'd0, size_q});
					pvalid_q[pool_q] <= 1'b1;
					if (new_pool_q) begin
						arenas_q <= arenas_q + AUW'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_data.buffer_number <= buf_wide[5:0];
						out_data.reused        <= reused_q;
						out_data.arena_number  <= full_q ? 4'd0 : arena_wide[3:0];
						out_data.arena_offset  <= off_q;
						out_data.table_full    <= full_q;
						out_data.planned_total <= planned_q;
						out_data.naive_total   <= naive_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The fill count never passes the table depth.
	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_q <= FULL_CNT) else $error("slot count overflow");

	// The remainder unit is never running while waiting for a new beat.
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !r_busy) else $error("divider busy in idle");

	// Slot reads only happen during the scan.
	a_scan_read: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == ST_SCAN)) else $error("slot read outside scan");

	// A new buffer always bumps the fill count by one.
	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEW) |=> (slots_q == $past(slots_q) + CW'(1)))
		else $error("fill count not advanced");

endmodule

>>> test/bfa_checker.sv
// Checker that predicts allocator results and compares them with the output beats.
module bfa_checker
	import bfa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	input  logic      cfg_we,
	input  logic [12:0] cfg_wdata,
	output int        fail_count,
	output int        pending_count
);

	logic [12:0] align_q;
	logic [63:0] buf_size [64];
	logic [15:0] buf_last [64];
	logic [3:0]  buf_pool [64];
	logic [63:0] buf_off  [64];
	int          bufs_made;
	logic        pool_seen [16];
	logic [3:0]  pool_arena [16];
	logic [63:0] pool_end [16];
	int          arenas_made;
	logic [63:0] planned_acc;
	logic [63:0] naive_acc;
	out_item_t   expected_allocs [$];

	function automatic logic [63:0] round_to_align(input logic [63:0] v,
		input logic [12:0] a);
		logic [63:0] d, r;
		d = (a == '0) ? 64'd1 : {51'd0, a};
		r = v % d;
		return (r == '0) ? v : v + (d - r);
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > {16'd0, SUM_MAX}) ? {16'd0, SUM_MAX} : s;
	endfunction

	// Best-fit allocation of one live range.
	task automatic allocate(input in_item_t it);
		logic [63:0] sz, off;
		logic [15:0] fs, ls;
		int best;
		out_item_t r;
		fs = it.first_step;
		ls = (it.last_step < fs) ? fs : it.last_step;
		sz = round_to_align({32'd0, it.byte_count}, align_q);
		naive_acc = add_sat(naive_acc, sz);
		best = -1;
		for (int i = 0; i < bufs_made; i++) begin
			if (buf_pool[i] == it.pool_id && buf_last[i] < fs && buf_size[i] >= sz)
				if (best < 0 || buf_size[i] < buf_size[best])
					best = i;
		end
		r = '0;
		if (best >= 0) begin
			buf_last[best] = ls;
			r.buffer_number = best[5:0];
			r.reused = 1'b1;
			r.arena_number = pool_arena[it.pool_id];
			r.arena_offset = buf_off[best][47:0];
		end else if (bufs_made >= 64) begin
			r.table_full = 1'b1;
		end else begin
			if (!pool_seen[it.pool_id]) begin
				pool_seen[it.pool_id] = 1'b1;
				pool_arena[it.pool_id] = arenas_made[3:0];
				arenas_made++;
				off = '0;
			end else begin
				off = round_to_align(pool_end[it.pool_id], align_q);
				if (off > {16'd0, SUM_MAX}) off = {16'd0, SUM_MAX};
			end
			pool_end[it.pool_id] = add_sat(off, sz);
			buf_size[bufs_made] = sz;
			buf_last[bufs_made] = ls;
			buf_pool[bufs_made] = it.pool_id;
			buf_off[bufs_made] = off;
			r.buffer_number = bufs_made[5:0];
			bufs_made++;
			planned_acc = add_sat(planned_acc, sz);
			r.arena_number = pool_arena[it.pool_id];
			r.arena_offset = off[47:0];
		end
		r.planned_total = planned_acc[47:0];
		r.naive_total = naive_acc[47:0];
		expected_allocs.insert(expected_allocs.size(), r);
	endtask

	// Track configuration, accepted inputs and accepted outputs.
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			align_q <= ALIGN_RST;
			bufs_made = 0;
			arenas_made = 0;
			planned_acc = '0;
			naive_acc = '0;
			fail_count <= 0;
			pending_count <= 0;
			for (int p = 0; p < 16; p++) begin
				pool_seen[p] = 1'b0;
				pool_end[p] = '0;
				pool_arena[p] = '0;
			end
			expected_allocs.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_allocs.size() == 0) begin
					$display("%0t: unexpected beat, actual %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_allocs.pop_front();
					if (e !== out_data) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) allocate(in_data);
			if (cfg_we) align_q <= cfg_wdata;
			pending_count <= expected_allocs.size();
		end
	end

endmodule

>>> test/testbench.sv
// Testbench top: stimulus, configuration phases and verdict for the allocator.
module testbench
	import bfa_pkg::*;
;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [12:0] cfg_wdata;
	int        fail_count;
	int        pending_count;
	int        cycle_count;
	bit        quiet_stretch;
	logic [15:0] step_now;

	best_fit_buffer_reuse_allocator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	bfa_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Random stall on the result side.
	always @(posedge clk) begin
		out_ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 11);
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("status: fail");
			$finish;
		end
	end

	// Send one beat, with an optional idle gap first; valid stays up until accepted.
	task automatic send_beat(input logic [3:0] p, input logic [15:0] f,
		input logic [15:0] l, input logic [31:0] b);
		while (!quiet_stretch && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{pool_id: p, first_step: f, last_step: l, byte_count: b};
		do @(posedge clk); while (!in_ready);
	endtask

	// Wait for all results, then let the block settle before a register write.
	task automatic drain_and_write(input logic [12:0] v);
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random phase of well-ordered live ranges with some noise.
	task automatic random_phase(input int n, input bit narrow_pools);
		logic [15:0] f, l;
		logic [31:0] b;
		logic [3:0] p;
		for (int i = 0; i < n; i++) begin
			quiet_stretch = (i >= n / 3 && i < n / 3 + 60);
			if ($urandom_range(9) == 0) begin
				f = 16'($urandom);
				l = 16'($urandom);
				b = $urandom;
				p = 4'($urandom);
			end else begin
				if ($urandom_range(2) == 0 && step_now < 16'hFFF0) step_now = step_now + 16'd1;
				f = step_now;
				l = ($urandom_range(19) == 0) ? f - 16'd1 : f + 16'($urandom_range(6));
				if (l < f && $urandom_range(1) == 1) l = f;
				b = ($urandom_range(15) == 0) ? $urandom : $urandom_range(5000);
				p = narrow_pools ? 4'($urandom_range(2)) : 4'($urandom);
			end
			send_beat(p, f, l, b);
		end
		quiet_stretch = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet_stretch = 0;
		step_now = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, clamping, reuse, full-size sizes.
		send_beat(4'd0, 16'd0, 16'd0, 32'd0);
		send_beat(4'd0, 16'd1, 16'd3, 32'd100);
		send_beat(4'd0, 16'd5, 16'd2, 32'd64);
		send_beat(4'd15, 16'd5, 16'd9, 32'hFFFF_FFFF);
		send_beat(4'd15, 16'd10, 16'd12, 32'hFFFF_FFFF);
		send_beat(4'd15, 16'd11, 16'd11, 32'hFFFF_FFFF);
		send_beat(4'd15, 16'd13, 16'hFFFF, 32'd1);
		send_beat(4'd7, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
		send_beat(4'd7, 16'hFFFF, 16'd0, 32'h5555_5555);
		send_beat(4'd0, 16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA);

		// Sender holds off until every result is back.
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);

		drain_and_write(13'd0);
		send_beat(4'd3, 16'd0, 16'd1, 32'd7);
		send_beat(4'd3, 16'd0, 16'd1, 32'd13);
		send_beat(4'd3, 16'd2, 16'd4, 32'd5);
		drain_and_write(13'h1FFF);
		send_beat(4'd3, 16'd2, 16'd3, 32'd9);
		send_beat(4'd9, 16'd3, 16'd3, 32'd1);
		drain_and_write(13'd4096);
		send_beat(4'd9, 16'd4, 16'd4, 32'd4097);
		drain_and_write(13'd1);

		// Random phases; the table fills over time, exercising the full flag.
		random_phase(400, 1'b1);
		drain_and_write(13'd3);
		random_phase(400, 1'b0);
		drain_and_write(13'd64);
		random_phase(350, 1'b1);
		drain_and_write(13'h1FFF);
		random_phase(300, 1'b0);

		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
